>>> design/assert_macros.svh
// Assertion helpers for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge of clk_i while out of reset.
`define PGR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same check, but also active during reset.
`define PGR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/pgr_pkg.sv
package pgr_pkg;

  // Default sizes of the font store and of the character cell.
  localparam int FontBytesDef = 8192;
  localparam int MaxCellDef   = 32;

  // Font table layout.
  localparam logic [7:0] END_CODE     = 8'hFF;
  localparam logic [7:0] XOFF_NEG     = 8'h80;
  localparam int         FirstRecord  = 4;
  localparam int         RecordLen    = 6;
  localparam int         HeightAddr   = 1;

  // Item kinds.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_RENDER = 1'b1;

  // One input item.
  typedef struct packed {
    logic        cmd;
    logic [12:0] font_addr;
    logic [7:0]  font_byte;
    logic [7:0]  char_code;
    logic [15:0] fg_color;
    logic [7:0]  pos_x;
    logic [6:0]  pos_y;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [31:0] row_mask;
    logic [4:0]  row_index;
    logic [5:0]  cell_width;
    logic [5:0]  cell_height;
    logic [15:0] color_out;
    logic [7:0]  x_out;
    logic [6:0]  y_out;
    logic        found;
    logic        last;
  } res_t;

endpackage

>>> design/proportional_glyph_rasterizer_top.sv
// Glyph rasterizer: table-write items (tuser 0) store one font byte each, straight
// from the idle state. A render item (tuser 1) first clears the cell rows, the
// smaller of MAX_CELL and 32 rows. It then fetches the cell height and reads each
// glyph record header in turn, the matched one included; the search also stops at
// an end code or at a header that would pass the store end. The bitmap of the found
// glyph is unpacked one bit per cycle, pausing for a byte fetch every eight bits.
// Each row is emitted once the output has taken the row before it. All of it is
// set by the single read port of the font store, which the header scan, the bitmap
// unpacking and the table writes share. One item is worked on at a time.
module proportional_glyph_rasterizer_top
  import pgr_pkg::*;
#(
  parameter int FONT_BYTES = FontBytesDef,
  parameter int MAX_CELL   = MaxCellDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // font_addr[12:0], font_byte[20:13], char_code[28:21], fg_color[44:29],
  // pos_x[52:45], pos_y[59:53], zero fill [63:60]
  input  logic [63:0] s_axis_tdata_i,
  // cmd[0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // row_mask[31:0], row_index[36:32], cell_width[42:37], cell_height[48:43],
  // color_out[64:49], x_out[72:65], y_out[79:73]
  output logic [79:0] m_axis_tdata_o,
  // found[0]
  output logic        m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int AW  = $clog2(FONT_BYTES);
  localparam int Cap = (MAX_CELL < 32) ? MAX_CELL : 32;
  localparam int RW  = $clog2(Cap);

  item_t         item;
  res_t          res;
  logic          font_we, cell_we;
  logic [AW-1:0] font_addr;
  logic [7:0]    font_wdata, font_rdata;
  logic [RW-1:0] cell_addr;
  logic [31:0]   cell_wdata, cell_rdata;
  logic [15:0]   bg_color_q;

  // Background color is held for the display side.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_color_q <= '0;
    end else if (cfg_valid_i) begin
      bg_color_q <= cfg_data_i;
    end
  end

  // Unpack the input item.
  assign item.cmd       = s_axis_tuser_i;
  assign item.font_addr = s_axis_tdata_i[12:0];
  assign item.font_byte = s_axis_tdata_i[20:13];
  assign item.char_code = s_axis_tdata_i[28:21];
  assign item.fg_color  = s_axis_tdata_i[44:29];
  assign item.pos_x     = s_axis_tdata_i[52:45];
  assign item.pos_y     = s_axis_tdata_i[59:53];

  pgr_seq #(
    .FONT_BYTES (FONT_BYTES),
    .MAX_CELL   (MAX_CELL)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_i         (item),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_o        (res),
    .font_we_o    (font_we),
    .font_addr_o  (font_addr),
    .font_wdata_o (font_wdata),
    .font_rdata_i (font_rdata),
    .cell_we_o    (cell_we),
    .cell_addr_o  (cell_addr),
    .cell_wdata_o (cell_wdata),
    .cell_rdata_i (cell_rdata)
  );

  pgr_ram #(
    .WIDTH (8),
    .DEPTH (FONT_BYTES)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (font_we),
    .addr_i  (font_addr),
    .wdata_i (font_wdata),
    .rdata_o (font_rdata)
  );

  pgr_ram #(
    .WIDTH (32),
    .DEPTH (Cap)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .addr_i  (cell_addr),
    .wdata_i (cell_wdata),
    .rdata_o (cell_rdata)
  );

  // Pack the result item.
  assign m_axis_tdata_o[31:0]  = res.row_mask;
  assign m_axis_tdata_o[36:32] = res.row_index;
  assign m_axis_tdata_o[42:37] = res.cell_width;
  assign m_axis_tdata_o[48:43] = res.cell_height;
  assign m_axis_tdata_o[64:49] = res.color_out;
  assign m_axis_tdata_o[72:65] = res.x_out;
  assign m_axis_tdata_o[79:73] = res.y_out;
  assign m_axis_tuser_o        = res.found;
  assign m_axis_tlast_o        = res.last;

endmodule

>>> design/pgr_ram.sv
module pgr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port, registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/pgr_seq.sv
module pgr_seq
  import pgr_pkg::*;
#(
  parameter int FONT_BYTES = FontBytesDef,
  parameter int MAX_CELL   = MaxCellDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  item_t                         in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output res_t                          out_o,
  output logic                          font_we_o,
  output logic [$clog2(FONT_BYTES)-1:0] font_addr_o,
  output logic [7:0]                    font_wdata_o,
  input  logic [7:0]                    font_rdata_i,
  output logic                          cell_we_o,
  output logic [$clog2((MAX_CELL < 32) ? MAX_CELL : 32)-1:0] cell_addr_o,
  output logic [31:0]                   cell_wdata_o,
  input  logic [31:0]                   cell_rdata_i
);

`include "assert_macros.svh"

  localparam int AW  = $clog2(FONT_BYTES);
  localparam int Cap = (MAX_CELL < 32) ? MAX_CELL : 32;
  localparam int RW  = $clog2(Cap);
  // Search pointer can run past the store by at most one bitmap skip.
  localparam int PW  = $clog2(FONT_BYTES + 8192) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_CH_RD, S_CH_WAIT, S_HDR_CHK, S_HDR_RD, S_HDR_WAIT,
    S_BM_RD, S_BM_WAIT, S_BM_BIT, S_EM_RD, S_EM_WAIT
  } state_e;

  state_e            state_q;
  logic [PW-1:0]     p_q;
  logic [2:0]        b_q;
  logic [7:0]        want_q, code_q, yoff_q, gw_q, gh_q, xraw_q, byte_q;
  logic [15:0]       fg_q;
  logic [7:0]        x_q;
  logic [6:0]        y_q;
  logic [5:0]        ch_q, cw_q, r_q;
  logic [15:0]       wh_q, k_q;
  logic [13:0]       skip_q;
  logic [RW-1:0]     clr_q;
  logic              hit_q, rd_oob_q, out_valid_q;
  logic signed [8:0] xoff_q;
  logic [7:0]        i_q, j_q;
  logic [31:0]       acc_q;
  res_t              out_q;

  logic [PW-1:0]     rd_full;
  logic              rd_oob;
  logic [7:0]        rd_data, gw_adv;
  logic              bit_set, col_ok, row_ok, row_end;
  logic signed [9:0] col;
  logic [8:0]        row_sum;
  logic [31:0]       acc_next;
  logic [5:0]        rows;

  // Font store read address for each phase of the search.
  always_comb begin
    case (state_q)
      S_CH_RD:  rd_full = PW'(HeightAddr);
      S_HDR_RD: rd_full = p_q + PW'(b_q);
      S_BM_RD:  rd_full = p_q + PW'(k_q[15:3]);
      default:  rd_full = p_q;
    endcase
  end

  // Reads past the end of the store return zero.
  assign rd_oob  = rd_full >= PW'(FONT_BYTES);
  assign rd_data = rd_oob_q ? 8'h00 : font_rdata_i;

  // Table writes go straight to the store from the idle state.
  assign in_ready_o   = (state_q == S_IDLE);
  assign font_we_o    = in_ready_o && in_valid_i && (in_i.cmd == CMD_WRITE);
  assign font_addr_o  = font_we_o ? AW'(in_i.font_addr) : rd_full[AW-1:0];
  assign font_wdata_o = in_i.font_byte;

  // Pixel placement for the bit under the cursor.
  assign bit_set  = byte_q[3'd7 - k_q[2:0]];
  assign col      = $signed({xoff_q[8], xoff_q}) + $signed({2'b00, i_q});
  assign col_ok   = !col[9] && (col[8:0] < {3'b000, cw_q});
  assign row_sum  = {1'b0, j_q} + {1'b0, yoff_q};
  assign row_ok   = row_sum < {3'b000, ch_q};
  assign row_end  = (i_q == gw_q - 8'd1);
  assign acc_next = acc_q | ((bit_set && col_ok) ? (32'd1 << col[4:0]) : 32'd0);
  assign gw_adv   = (gw_q > rd_data) ? gw_q : rd_data;
  assign rows     = (hit_q && ch_q != 6'd0) ? ch_q : 6'd1;

  // Cell row store: cleared at render start, written once per glyph row that falls inside the cell.
  always_comb begin
    cell_we_o    = 1'b0;
    cell_addr_o  = r_q[RW-1:0];
    cell_wdata_o = '0;
    case (state_q)
      S_CLEAR: begin
        cell_we_o   = 1'b1;
        cell_addr_o = clr_q;
      end
      S_BM_BIT: begin
        cell_we_o    = row_end && row_ok;
        cell_addr_o  = row_sum[RW-1:0];
        cell_wdata_o = acc_next;
      end
      default: ;
    endcase
  end

  // Sequencer: search, unpack, then emit one item per cell row, at least one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      rd_oob_q    <= 1'b0;
      p_q         <= '0;
      b_q         <= '0;
      clr_q       <= '0;
      r_q         <= '0;
      cw_q        <= '0;
      ch_q        <= '0;
    end else begin
      rd_oob_q <= rd_oob;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_i.cmd == CMD_RENDER) begin
            want_q  <= in_i.char_code;
            fg_q    <= in_i.fg_color;
            x_q     <= in_i.pos_x;
            y_q     <= in_i.pos_y;
            hit_q   <= 1'b0;
            cw_q    <= '0;
            clr_q   <= '0;
            r_q     <= '0;
            p_q     <= PW'(FirstRecord);
            state_q <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          clr_q <= clr_q + RW'(1);
          if (clr_q == RW'(Cap - 1)) begin
            state_q <= S_CH_RD;
          end
        end
        S_CH_RD: state_q <= S_CH_WAIT;
        S_CH_WAIT: begin
          ch_q    <= (rd_data > 8'(Cap)) ? 6'(Cap) : rd_data[5:0];
          state_q <= S_HDR_CHK;
        end
        S_HDR_CHK: begin
          b_q <= '0;
          if ((p_q + PW'(RecordLen)) > PW'(FONT_BYTES)) begin
            state_q <= S_EM_RD;
          end else begin
            state_q <= S_HDR_RD;
          end
        end
        S_HDR_RD: state_q <= S_HDR_WAIT;
        S_HDR_WAIT: begin
          b_q     <= b_q + 3'd1;
          state_q <= S_HDR_RD;
          case (b_q)
            3'd0: begin
              code_q <= rd_data;
              if (rd_data == END_CODE) begin
                state_q <= S_EM_RD;
              end
            end
            3'd1: yoff_q <= rd_data;
            3'd2: gw_q <= rd_data;
            3'd3: begin
              gh_q <= rd_data;
              wh_q <= 16'(gw_q) * 16'(rd_data);
            end
            3'd4: begin
              xraw_q <= rd_data;
              if (gw_q == 8'd0) begin
                skip_q <= '0;
              end else if (wh_q == 16'd0) begin
                skip_q <= 14'd1;
              end else begin
                skip_q <= 14'((wh_q - 16'd1) >> 3) + 14'd1;
              end
            end
            3'd5: begin
              if (code_q == want_q) begin
                // Glyph found: bitmap starts right after the header.
                hit_q  <= 1'b1;
                p_q    <= p_q + PW'(RecordLen);
                cw_q   <= (gw_adv > 8'(Cap)) ? 6'(Cap) : gw_adv[5:0];
                xoff_q <= (xraw_q < XOFF_NEG) ? $signed({1'b0, xraw_q})
                                              : $signed({1'b0, xraw_q} - 9'd255);
                i_q    <= '0;
                j_q    <= '0;
                k_q    <= '0;
                acc_q  <= '0;
                if (gw_q == 8'd0 || gh_q == 8'd0) begin
                  state_q <= S_EM_RD;
                end else begin
                  state_q <= S_BM_RD;
                end
              end else begin
                p_q     <= p_q + PW'(RecordLen) + PW'(skip_q);
                state_q <= S_HDR_CHK;
              end
            end
            default: state_q <= S_HDR_CHK;
          endcase
        end
        S_BM_RD: state_q <= S_BM_WAIT;
        S_BM_WAIT: begin
          byte_q  <= rd_data;
          state_q <= S_BM_BIT;
        end
        S_BM_BIT: begin
          k_q <= k_q + 16'd1;
          if (k_q[2:0] == 3'd7) begin
            state_q <= S_BM_RD;
          end
          if (row_end) begin
            i_q   <= '0;
            j_q   <= j_q + 8'd1;
            acc_q <= '0;
            if (j_q == gh_q - 8'd1) begin
              state_q <= S_EM_RD;
            end
          end else begin
            i_q   <= i_q + 8'd1;
            acc_q <= acc_next;
          end
        end
        S_EM_RD: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= S_EM_WAIT;
          end
        end
        S_EM_WAIT: begin
          out_valid_q       <= 1'b1;
          out_q.row_mask    <= hit_q ? cell_rdata_i : 32'd0;
          out_q.row_index   <= r_q[4:0];
          out_q.cell_width  <= cw_q;
          out_q.cell_height <= ch_q;
          out_q.color_out   <= fg_q;
          out_q.x_out       <= x_q;
          out_q.y_out       <= y_q;
          out_q.found       <= hit_q;
          out_q.last        <= (r_q + 6'd1 == rows);
          if (r_q + 6'd1 == rows) begin
            state_q <= S_IDLE;
          end else begin
            r_q     <= r_q + 6'd1;
            state_q <= S_EM_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `PGR_ASSERT(a_miss_single, out_valid_q && !out_q.found |-> out_q.last && out_q.row_mask == '0 && out_q.row_index == '0, "missing glyph must give one empty final row")
  `PGR_ASSERT(a_row_in_cell, out_valid_q && out_q.found && out_q.cell_height != '0 |-> 6'(out_q.row_index) < out_q.cell_height, "row index beyond cell height")
  `PGR_ASSERT(a_cell_wr_hit, cell_we_o && state_q == S_BM_BIT |-> hit_q, "cell row written without a found glyph")

endmodule
